// ===== rtl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, character codes and helpers for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  typedef enum logic [4:0] {
    MODE_PLAIN = 5'b00001,
    MODE_ESC   = 5'b00010,
    MODE_HEX   = 5'b00100,
    MODE_OCT   = 5'b01000,
    MODE_STOP  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bad_escape;
    logic       stop_seen;
    logic       last_of_string;
  } result_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_C         = 8'h63;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;

  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_VT  = 8'd11;

  // {is_digit, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic result_t make_res(input logic [7:0] b, input logic bv,
                                       input logic bad, input logic stop);
    result_t r;
    r.out_byte       = bv ? b : 8'h00;
    r.byte_valid     = bv;
    r.bad_escape     = bad;
    r.stop_seen      = stop;
    r.last_of_string = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/bed_decode.sv =====
// ----------------------------------------------------------------------------
// bed_decode
// Escape state and single-pass decode of one registered character into up
// to two results.
// ----------------------------------------------------------------------------
module bed_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_char,
  input  logic              end_of_string,
  input  logic              advance,
  output bed_pkg::result_t  res0,
  output bed_pkg::result_t  res1,
  output logic [1:0]        nres
);

  bed_pkg::mode_t mode, mode_next, mode_m;
  logic [1:0]     digit_count, digit_count_next, cnt_m;
  logic [7:0]     escape_value, escape_value_next, val_m;

  bed_pkg::result_t a, b, e;
  logic             a_vld, b_vld, e_vld;
  logic [4:0]       hexd;
  logic             is_hex, oct_ok, dig_ok;
  logic [3:0]       dig;
  logic [7:0]       nv;

  always_comb begin
    hexd   = bed_pkg::hex_value(in_char);
    is_hex = (mode == bed_pkg::MODE_HEX);
    oct_ok = (in_char[7:3] == 5'b00110);
    dig_ok = is_hex ? hexd[4] : oct_ok;
    dig    = is_hex ? hexd[3:0] : {1'b0, in_char[2:0]};
    nv     = is_hex ? {escape_value[3:0], dig} : {escape_value[4:0], dig[2:0]};

    mode_m = mode;
    cnt_m  = digit_count;
    val_m  = escape_value;
    a      = '0;
    b      = '0;
    e      = '0;
    a_vld  = 1'b0;
    b_vld  = 1'b0;
    e_vld  = 1'b0;

    unique case (mode)
      bed_pkg::MODE_STOP: begin
      end
      bed_pkg::MODE_ESC: begin
        mode_m = bed_pkg::MODE_PLAIN;
        cnt_m  = 2'd0;
        val_m  = 8'd0;
        a_vld  = 1'b1;
        unique case (in_char)
          bed_pkg::CH_X: begin
            mode_m = bed_pkg::MODE_HEX;
            a_vld  = 1'b0;
          end
          bed_pkg::CH_ZERO: begin
            mode_m = bed_pkg::MODE_OCT;
            a_vld  = 1'b0;
          end
          bed_pkg::CH_C: begin
            mode_m = bed_pkg::MODE_STOP;
            a      = bed_pkg::make_res(8'd0, 1'b0, 1'b0, 1'b1);
          end
          bed_pkg::CH_QUOTE:     a = bed_pkg::make_res(bed_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
          bed_pkg::CH_BACKSLASH: a = bed_pkg::make_res(bed_pkg::CH_BACKSLASH, 1'b1, 1'b0,
                                                       1'b0);
          bed_pkg::CH_A: a = bed_pkg::make_res(bed_pkg::CODE_BEL, 1'b1, 1'b0, 1'b0);
          bed_pkg::CH_B: a = bed_pkg::make_res(bed_pkg::CODE_BS, 1'b1, 1'b0, 1'b0);
          bed_pkg::CH_F: a = bed_pkg::make_res(bed_pkg::CODE_FF, 1'b1, 1'b0, 1'b0);
          bed_pkg::CH_N: a = bed_pkg::make_res(bed_pkg::CODE_LF, 1'b1, 1'b0, 1'b0);
          bed_pkg::CH_R: a = bed_pkg::make_res(bed_pkg::CODE_CR, 1'b1, 1'b0, 1'b0);
          bed_pkg::CH_T: a = bed_pkg::make_res(bed_pkg::CODE_HT, 1'b1, 1'b0, 1'b0);
          bed_pkg::CH_V: a = bed_pkg::make_res(bed_pkg::CODE_VT, 1'b1, 1'b0, 1'b0);
          default:       a = bed_pkg::make_res(in_char, 1'b1, 1'b1, 1'b0);
        endcase
      end
      bed_pkg::MODE_HEX, bed_pkg::MODE_OCT: begin
        if (dig_ok) begin
          if (digit_count == 2'd2) begin
            a_vld  = 1'b1;
            a      = bed_pkg::make_res(nv, 1'b1, 1'b0, 1'b0);
            mode_m = bed_pkg::MODE_PLAIN;
            cnt_m  = 2'd0;
            val_m  = 8'd0;
          end else begin
            cnt_m = digit_count + 2'd1;
            val_m = nv;
          end
        end else begin
          // terminator ends the number, then is taken as plain text, or opens a new escape if it is a backslash
          a_vld  = 1'b1;
          a      = bed_pkg::make_res(escape_value, 1'b1,
                                     is_hex && (digit_count == 2'd0), 1'b0);
          mode_m = bed_pkg::MODE_PLAIN;
          cnt_m  = 2'd0;
          val_m  = 8'd0;
          if (in_char == bed_pkg::CH_BACKSLASH) begin
            mode_m = bed_pkg::MODE_ESC;
          end else begin
            b_vld = 1'b1;
            b     = bed_pkg::make_res(in_char, 1'b1, 1'b0, 1'b0);
          end
        end
      end
      default: begin
        if (in_char == bed_pkg::CH_BACKSLASH) begin
          mode_m = bed_pkg::MODE_ESC;
        end else begin
          a_vld = 1'b1;
          a     = bed_pkg::make_res(in_char, 1'b1, 1'b0, 1'b0);
        end
      end
    endcase

    mode_next         = mode_m;
    digit_count_next  = cnt_m;
    escape_value_next = val_m;
    if (end_of_string && (mode != bed_pkg::MODE_STOP)) begin
      if (mode_m == bed_pkg::MODE_ESC) begin
        e_vld = 1'b1;
        e     = bed_pkg::make_res(8'd0, 1'b0, 1'b1, 1'b0);
      end else if (mode_m == bed_pkg::MODE_HEX) begin
        e_vld = 1'b1;
        e     = bed_pkg::make_res(val_m, 1'b1, cnt_m == 2'd0, 1'b0);
      end else if (mode_m == bed_pkg::MODE_OCT) begin
        e_vld = 1'b1;
        e     = bed_pkg::make_res(val_m, 1'b1, 1'b0, 1'b0);
      end
      if (mode_m != bed_pkg::MODE_STOP) begin
        mode_next = bed_pkg::MODE_PLAIN;
      end
      digit_count_next  = 2'd0;
      escape_value_next = 8'd0;
    end

    res0 = a_vld ? a : e;
    res1 = b_vld ? b : e;
    nres = {1'b0, a_vld} + {1'b0, b_vld} + {1'b0, e_vld};
    if (end_of_string) begin
      if (nres == 2'd2) begin
        res1.last_of_string = 1'b1;
      end else if (nres == 2'd1) begin
        res0.last_of_string = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= bed_pkg::MODE_PLAIN;
      digit_count  <= 2'd0;
      escape_value <= 8'd0;
    end else if (advance) begin
      mode         <= mode_next;
      digit_count  <= digit_count_next;
      escape_value <= escape_value_next;
    end
  end

  a_mode_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(mode))
    else $error("decode mode not one-hot");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == bed_pkg::MODE_STOP |=> mode == bed_pkg::MODE_STOP)
    else $error("left stopped mode without reset");

  a_stop_silent: assert property (@(posedge clk) disable iff (rst)
    mode == bed_pkg::MODE_STOP |-> nres == 2'd0)
    else $error("results produced while stopped");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count != 2'd3)
    else $error("digit count overflow");

endmodule

// ===== rtl/bed_outbuf.sv =====
// ----------------------------------------------------------------------------
// bed_outbuf
// Two-entry result register; presents one result per output handshake.
// ----------------------------------------------------------------------------
module bed_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bed_pkg::result_t  res0,
  input  bed_pkg::result_t  res1,
  input  logic [1:0]        nres,
  input  logic              out_stall,
  output logic              out_valid,
  output bed_pkg::result_t  head,
  output logic              can_load
);

  bed_pkg::result_t slot0, slot1;
  logic [1:0]       cnt, cnt_next;
  logic             take;

  assign out_valid = (cnt != 2'd0);
  assign head      = slot0;
  assign take      = out_valid && !out_stall;
  assign can_load  = (cnt == 2'd0) || ((cnt == 2'd1) && take);

  always_comb begin
    cnt_next = cnt;
    if (load) begin
      cnt_next = nres;
    end else if (take) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result count overflow");

  a_load_safe: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == 2'd0 || (cnt == 2'd1 && take)))
    else $error("load over pending results");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && take) |=> (out_valid && $past(slot1) == slot0))
    else $error("second result lost");

endmodule

// ===== rtl/backslash_escape_decoder.sv =====
// A result is offered after its character passes the input register and the
// two-entry result register. Throughput: one character per cycle while the
// output does not stall; a character with two results holds the input while
// both are pending, since the output moves one result per cycle.
// Reset (rst, synchronous) empties both registers and returns to plain text.
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes a character stream with backslash escapes into output bytes.
// ----------------------------------------------------------------------------
module backslash_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       bad_escape,
  output logic       stop_seen,
  output logic       last_of_string
);

  logic             full;
  logic [7:0]       ch;
  logic             eos;
  logic             advance;
  logic             can_load;
  logic [1:0]       nres;
  bed_pkg::result_t res0, res1, head;

  assign advance  = full && ((nres == 2'd0) || can_load);
  assign in_stall = full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ch  <= in_char;
      eos <= end_of_string;
    end
  end

  bed_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_char       (ch),
    .end_of_string (eos),
    .advance       (advance),
    .res0          (res0),
    .res1          (res1),
    .nres          (nres)
  );

  bed_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && (nres != 2'd0)),
    .res0      (res0),
    .res1      (res1),
    .nres      (nres),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .can_load  (can_load)
  );

  assign out_byte       = head.out_byte;
  assign byte_valid     = head.byte_valid;
  assign bad_escape     = head.bad_escape;
  assign stop_seen      = head.stop_seen;
  assign last_of_string = head.last_of_string;

endmodule
